// ===== rtl/per_key_join_rate_blocker_assert.svh =====
// assertion macros for the per-source rate limiter
// no dependencies; expects clk and rst_n in the including module
`ifndef PER_KEY_JOIN_RATE_BLOCKER_ASSERT_SVH
`define PER_KEY_JOIN_RATE_BLOCKER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PJRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PJRB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PJRB_ASSERT_IMP(lbl, ante, cons, msg)
`define PJRB_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/pjrb_pkg.sv =====
// shared types and constants for the per-source rate limiter
// no dependencies
`timescale 1ns / 1ps

package pjrb_pkg;

  // default table depths
  localparam int TRACK_ENTRIES_DEF = 64;
  localparam int BLOCK_ENTRIES_DEF = 64;

  // field widths
  localparam int KEY_W     = 64;
  localparam int NOW_W     = 32;
  localparam int DL_W      = 33;
  localparam int CNT_W     = 5;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // operation codes
  localparam logic [1:0] OP_CHECK   = 2'd0;
  localparam logic [1:0] OP_COUNT   = 2'd1;
  localparam logic [1:0] OP_UNBLOCK = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // verdict codes
  localparam logic [1:0] V_ALLOW   = 2'd0;
  localparam logic [1:0] V_BLOCKED = 2'd1;
  localparam logic [1:0] V_NEWBLK  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK  = 2'd2;

  // tracker memory word
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [DL_W-1:0]  dl;
    logic [CNT_W-1:0] cnt;
  } trk_ent_t;

  // blocklist memory word
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [DL_W-1:0]  dl;
  } blk_ent_t;

  // scan control from the sequencer to both tables
  typedef struct packed {
    logic start;
    logic rd_en;
  } scan_ctl_t;

endpackage

// ===== rtl/per_key_join_rate_blocker.sv =====
// top level of the per-source fixed-window rate limiter with blocklist
// depends on pjrb_pkg, pjrb_track, pjrb_block and the assertion macro header
`timescale 1ns / 1ps

`include "per_key_join_rate_blocker_assert.svh"

// Per-source rate limiter. Raise start for one cycle while busy is low to hand
// in one beat (opcode, source key, time). Every beat yields exactly one result,
// shown on out_verdict / out_table_full for a single cycle with out_valid high;
// the result cannot be held off, so capture it when out_valid is seen.
// Opcodes 0 to 2 scan both table memories, one entry per cycle in parallel,
// then pass through a drain state and a write-back state, plus a second
// write-back state when an admission check clears an expired block entry and
// stores the new block in another slot; opcode 3 gives its result on the next
// cycle. A new beat may be started in the cycle the result is shown. After
// reset the block runs a clearing pass over both tables with busy high.
// Configuration writes are taken at any time but must only be issued
// while no beat is in flight.
module per_key_join_rate_blocker #(
  parameter int TRACK_ENTRIES = pjrb_pkg::TRACK_ENTRIES_DEF,
  parameter int BLOCK_ENTRIES = pjrb_pkg::BLOCK_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_opcode,
  input  logic [pjrb_pkg::KEY_W-1:0]     in_source_key,
  input  logic [pjrb_pkg::NOW_W-1:0]     in_now_seconds,
  output logic                           out_valid,
  output logic [1:0]                     out_verdict,
  output logic                           out_table_full,
  input  logic                           cfg_we,
  input  logic [pjrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pjrb_pkg::CFG_W-1:0]     cfg_data
);

  localparam int MAXE = (TRACK_ENTRIES > BLOCK_ENTRIES) ? TRACK_ENTRIES : BLOCK_ENTRIES;
  localparam int CW   = $clog2(MAXE);
  localparam int TAW  = $clog2(TRACK_ENTRIES);
  localparam int BAW  = $clog2(BLOCK_ENTRIES);
  localparam logic [CW-1:0] LAST_ADDR = CW'(MAXE - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_WR1   = 6'b010000,
    S_WR2   = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CW-1:0]                   addr_r, addr_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [1:0]                      out_verdict_r;
  logic                            out_full_r;

  logic [1:0]                      op_r;
  logic [pjrb_pkg::KEY_W-1:0]      key_r;
  logic [pjrb_pkg::NOW_W-1:0]      now_r;

  logic [pjrb_pkg::CNT_W-1:0]      limit_r;
  logic [pjrb_pkg::CFG_W-1:0]      window_r;
  logic [pjrb_pkg::CFG_W-1:0]      blk_time_r;

  pjrb_pkg::scan_ctl_t             t_ctl, b_ctl;
  logic                            t_in_range, b_in_range;
  logic                            t_we, b_we;
  logic [TAW-1:0]                  t_waddr;
  logic [BAW-1:0]                  b_waddr;
  pjrb_pkg::trk_ent_t              t_went;
  pjrb_pkg::blk_ent_t              b_went;

  logic                            t_hit, t_free;
  logic [TAW-1:0]                  t_hit_idx, t_free_idx;
  logic [pjrb_pkg::DL_W-1:0]       t_hit_dl;
  logic [pjrb_pkg::CNT_W-1:0]      t_hit_cnt;
  logic                            b_hit, b_free;
  logic [BAW-1:0]                  b_hit_idx, b_free_idx;
  logic [pjrb_pkg::DL_W-1:0]       b_hit_dl;

  logic [pjrb_pkg::DL_W-1:0]       now_ext, now_win, now_blk;
  logic                            t_exp, t_at_limit, b_exp;
  logic                            blocked, trip, blk_inv, blk_ins, need_wr2;
  logic                            res_load;
  logic [1:0]                      res_verdict;
  logic                            res_full;
  logic                            accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= pjrb_pkg::CNT_W'(2);
      window_r   <= pjrb_pkg::CFG_W'(1);
      blk_time_r <= pjrb_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pjrb_pkg::CFG_LIMIT:  limit_r    <= cfg_data[pjrb_pkg::CNT_W-1:0];
        pjrb_pkg::CFG_WINDOW: window_r   <= cfg_data;
        pjrb_pkg::CFG_BLOCK:  blk_time_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_opcode;
      key_r <= in_source_key;
      now_r <= in_now_seconds;
    end
  end

  // deadlines and expiry tests on the captured scan results
  assign now_ext    = {1'b0, now_r};
  assign now_win    = now_ext + {{(pjrb_pkg::DL_W - pjrb_pkg::CFG_W){1'b0}}, window_r};
  assign now_blk    = now_ext + {{(pjrb_pkg::DL_W - pjrb_pkg::CFG_W){1'b0}}, blk_time_r};
  assign t_exp      = now_ext > t_hit_dl;
  assign t_at_limit = t_hit_cnt >= limit_r;
  assign b_exp      = now_ext > b_hit_dl;
  assign blocked    = b_hit && !b_exp;
  assign trip       = !blocked && t_hit && !t_exp && t_at_limit;
  assign blk_inv    = b_hit && b_exp;
  assign blk_ins    = trip && b_free;
  assign need_wr2   = (op_r == pjrb_pkg::OP_CHECK) && blk_inv && blk_ins &&
                      (b_hit_idx != b_free_idx);

  // table range checks for the shared address counter
  assign t_in_range = {1'b0, addr_r} < (CW + 1)'(TRACK_ENTRIES);
  assign b_in_range = {1'b0, addr_r} < (CW + 1)'(BLOCK_ENTRIES);

  // scan control
  always_comb begin
    t_ctl.start = accept;
    b_ctl.start = accept;
    t_ctl.rd_en = (state_r == S_SCAN) && t_in_range;
    b_ctl.rd_en = (state_r == S_SCAN) && b_in_range;
  end

  // write-back selection
  always_comb begin
    t_we        = 1'b0;
    t_waddr     = addr_r[TAW-1:0];
    t_went      = '{valid: 1'b1, key: key_r, dl: now_win, cnt: pjrb_pkg::CNT_W'(1)};
    b_we        = 1'b0;
    b_waddr     = b_free_idx;
    b_went      = '{valid: 1'b1, key: key_r, dl: now_blk};
    res_verdict = pjrb_pkg::V_ALLOW;
    res_full    = 1'b0;
    res_load    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        t_we         = t_in_range;
        t_went.valid = 1'b0;
        b_we         = b_in_range;
        b_waddr      = addr_r[BAW-1:0];
        b_went.valid = 1'b0;
      end
      S_IDLE: begin
        res_load = accept && (in_opcode == pjrb_pkg::OP_NONE);
      end
      S_WR1: begin
        res_load = 1'b1;
        case (op_r)
          pjrb_pkg::OP_COUNT: begin
            if (t_hit) begin
              t_we    = 1'b1;
              t_waddr = t_hit_idx;
              if (!(t_exp || t_at_limit)) begin
                t_went.dl  = t_hit_dl;
                t_went.cnt = t_hit_cnt + pjrb_pkg::CNT_W'(1);
              end
            end else if (t_free) begin
              t_we    = 1'b1;
              t_waddr = t_free_idx;
            end else begin
              res_full = 1'b1;
            end
          end
          pjrb_pkg::OP_CHECK: begin
            if (blocked) begin
              res_verdict = pjrb_pkg::V_BLOCKED;
            end else begin
              // expired or tripped tracker entries are dropped
              if (t_hit && (t_exp || t_at_limit)) begin
                t_we         = 1'b1;
                t_waddr      = t_hit_idx;
                t_went.valid = 1'b0;
              end
              if (trip) begin
                res_verdict = pjrb_pkg::V_NEWBLK;
                res_full    = !b_free;
              end
              // stale block entry goes first unless the new block lands on it
              if (blk_inv && !(blk_ins && (b_hit_idx == b_free_idx))) begin
                b_we         = 1'b1;
                b_waddr      = b_hit_idx;
                b_went.valid = 1'b0;
              end else if (blk_ins) begin
                b_we = 1'b1;
              end
            end
          end
          pjrb_pkg::OP_UNBLOCK: begin
            if (b_hit) begin
              b_we         = 1'b1;
              b_waddr      = b_hit_idx;
              b_went.valid = 1'b0;
            end
          end
          default: ;
        endcase
      end
      S_WR2: begin
        // deferred block insert
        b_we = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
          addr_nxt  = '0;
        end else begin
          addr_nxt = addr_r + CW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == pjrb_pkg::OP_NONE) begin
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = S_SCAN;
            addr_nxt  = '0;
          end
        end
      end
      S_SCAN: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = S_DRAIN;
        end else begin
          addr_nxt = addr_r + CW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_WR1;
      end
      S_WR1: begin
        if (need_wr2) begin
          state_nxt = S_WR2;
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      S_WR2: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_verdict_r <= res_verdict;
      out_full_r    <= res_full;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_verdict    = out_verdict_r;
  assign out_table_full = out_full_r;

  // tracker table
  pjrb_track #(
    .DEPTH (TRACK_ENTRIES)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (t_ctl),
    .rd_addr    (addr_r[TAW-1:0]),
    .key        (key_r),
    .now        (now_r),
    .wr_en      (t_we),
    .wr_addr    (t_waddr),
    .wr_ent     (t_went),
    .hit        (t_hit),
    .hit_idx    (t_hit_idx),
    .hit_dl     (t_hit_dl),
    .hit_cnt    (t_hit_cnt),
    .free_found (t_free),
    .free_idx   (t_free_idx)
  );

  // blocklist table
  pjrb_block #(
    .DEPTH (BLOCK_ENTRIES)
  ) u_block (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (b_ctl),
    .rd_addr    (addr_r[BAW-1:0]),
    .key        (key_r),
    .now        (now_r),
    .wr_en      (b_we),
    .wr_addr    (b_waddr),
    .wr_ent     (b_went),
    .hit        (b_hit),
    .hit_idx    (b_hit_idx),
    .hit_dl     (b_hit_dl),
    .free_found (b_free),
    .free_idx   (b_free_idx)
  );

  // checks
  `PJRB_ASSERT_NXT(a_beat_starts, start && !busy, (state_r == S_SCAN) || out_valid, "beat lost")
  `PJRB_ASSERT_IMP(a_clear_quiet, state_r == S_CLEAR, !out_valid, "result during clear")
  `PJRB_ASSERT_IMP(a_wr2_order, state_r == S_WR2, $past(state_r) == S_WR1, "bad write order")
  `PJRB_ASSERT_IMP(a_blocked_fits, out_valid && (out_verdict == pjrb_pkg::V_BLOCKED), !out_table_full, "full flag on blocked")

endmodule

// ===== rtl/pjrb_track.sv =====
// tracker table: registered-read memory plus first-match / first-free scan capture
// depends on pjrb_pkg
`timescale 1ns / 1ps

module pjrb_track #(
  parameter int DEPTH = pjrb_pkg::TRACK_ENTRIES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pjrb_pkg::scan_ctl_t         ctl,
  input  logic [AW-1:0]               rd_addr,
  input  logic [pjrb_pkg::KEY_W-1:0]  key,
  input  logic [pjrb_pkg::NOW_W-1:0]  now,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  pjrb_pkg::trk_ent_t          wr_ent,
  output logic                        hit,
  output logic [AW-1:0]               hit_idx,
  output logic [pjrb_pkg::DL_W-1:0]   hit_dl,
  output logic [pjrb_pkg::CNT_W-1:0]  hit_cnt,
  output logic                        free_found,
  output logic [AW-1:0]               free_idx
);

  pjrb_pkg::trk_ent_t               mem_r [DEPTH];
  pjrb_pkg::trk_ent_t               rd_q_r;
  logic [AW-1:0]                    rd_idx_r;
  logic                             rd_vld_r;
  logic                             hit_r;
  logic                             free_r;
  logic [AW-1:0]                    hit_idx_r;
  logic [pjrb_pkg::DL_W-1:0]        hit_dl_r;
  logic [pjrb_pkg::CNT_W-1:0]       hit_cnt_r;
  logic [AW-1:0]                    free_idx_r;
  logic                             match;
  logic                             vacant;

  // memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_ent;
    end
    if (ctl.rd_en) begin
      rd_q_r   <= mem_r[rd_addr];
      rd_idx_r <= rd_addr;
    end
  end

  // compare the returned word
  assign match  = rd_q_r.valid && (rd_q_r.key == key);
  assign vacant = !rd_q_r.valid || ({1'b0, now} > rd_q_r.dl);

  // scan flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
    end else begin
      rd_vld_r <= ctl.rd_en;
      if (ctl.start) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (rd_vld_r) begin
        if (!hit_r && match) begin
          hit_r <= 1'b1;
        end
        if (!free_r && vacant) begin
          free_r <= 1'b1;
        end
      end
    end
  end

  // captured entry details, lowest index wins
  always_ff @(posedge clk) begin
    if (rd_vld_r && !ctl.start) begin
      if (!hit_r && match) begin
        hit_idx_r <= rd_idx_r;
        hit_dl_r  <= rd_q_r.dl;
        hit_cnt_r <= rd_q_r.cnt;
      end
      if (!free_r && vacant) begin
        free_idx_r <= rd_idx_r;
      end
    end
  end

  assign hit        = hit_r;
  assign hit_idx    = hit_idx_r;
  assign hit_dl     = hit_dl_r;
  assign hit_cnt    = hit_cnt_r;
  assign free_found = free_r;
  assign free_idx   = free_idx_r;

endmodule

// ===== rtl/pjrb_block.sv =====
// blocklist table: registered-read memory plus first-match / first-free scan capture
// depends on pjrb_pkg
`timescale 1ns / 1ps

module pjrb_block #(
  parameter int DEPTH = pjrb_pkg::BLOCK_ENTRIES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pjrb_pkg::scan_ctl_t         ctl,
  input  logic [AW-1:0]               rd_addr,
  input  logic [pjrb_pkg::KEY_W-1:0]  key,
  input  logic [pjrb_pkg::NOW_W-1:0]  now,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  pjrb_pkg::blk_ent_t          wr_ent,
  output logic                        hit,
  output logic [AW-1:0]               hit_idx,
  output logic [pjrb_pkg::DL_W-1:0]   hit_dl,
  output logic                        free_found,
  output logic [AW-1:0]               free_idx
);

  pjrb_pkg::blk_ent_t               mem_r [DEPTH];
  pjrb_pkg::blk_ent_t               rd_q_r;
  logic [AW-1:0]                    rd_idx_r;
  logic                             rd_vld_r;
  logic                             hit_r;
  logic                             free_r;
  logic [AW-1:0]                    hit_idx_r;
  logic [pjrb_pkg::DL_W-1:0]        hit_dl_r;
  logic [AW-1:0]                    free_idx_r;
  logic                             match;
  logic                             vacant;

  // memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_ent;
    end
    if (ctl.rd_en) begin
      rd_q_r   <= mem_r[rd_addr];
      rd_idx_r <= rd_addr;
    end
  end

  // compare the returned word
  assign match  = rd_q_r.valid && (rd_q_r.key == key);
  assign vacant = !rd_q_r.valid || ({1'b0, now} > rd_q_r.dl);

  // scan flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
    end else begin
      rd_vld_r <= ctl.rd_en;
      if (ctl.start) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (rd_vld_r) begin
        if (!hit_r && match) begin
          hit_r <= 1'b1;
        end
        if (!free_r && vacant) begin
          free_r <= 1'b1;
        end
      end
    end
  end

  // captured entry details, lowest index wins
  always_ff @(posedge clk) begin
    if (rd_vld_r && !ctl.start) begin
      if (!hit_r && match) begin
        hit_idx_r <= rd_idx_r;
        hit_dl_r  <= rd_q_r.dl;
      end
      if (!free_r && vacant) begin
        free_idx_r <= rd_idx_r;
      end
    end
  end

  assign hit        = hit_r;
  assign hit_idx    = hit_idx_r;
  assign hit_dl     = hit_dl_r;
  assign free_found = free_r;
  assign free_idx   = free_idx_r;

endmodule
